// ===== design/gfle_pkg.sv =====
// gfle_pkg: shared types, widths, codes and field helpers for the GF(2^m)
// exponent / logarithm table builder.
// No dependencies; used by gf2m_log_exp_table_builder.
package gfle_pkg;

  localparam int MAX_FIELD_BITS = 12;
  localparam int ELEM_W         = MAX_FIELD_BITS;
  localparam int POLY_W         = ELEM_W + 1;
  localparam int DEG_W          = $clog2(POLY_W);
  localparam int IDX_W          = $clog2(ELEM_W);
  localparam int PH_W           = $clog2(2 * ELEM_W - 1);
  localparam int STORE_DEPTH    = 1 << ELEM_W;
  localparam int CMD_W          = 2;
  localparam int STAT_W         = 2;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = POLY_W;

  // commands
  localparam logic [CMD_W-1:0] CMD_BUILD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ_EXP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ_LOG = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_PRIM  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_BUILT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GENERATOR = 1'd1;

  localparam logic [POLY_W-1:0] MODULUS_RST   = POLY_W'(4107);
  localparam logic [ELEM_W-1:0] GENERATOR_RST = ELEM_W'(2);

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ELEM_W-1:0] operand;
  } in_item_t;

  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic [STAT_W-1:0] status;
  } out_item_t;

  // index of the highest set bit; 0 for 0 and 1
  function automatic logic [DEG_W-1:0] poly_degree(input logic [POLY_W-1:0] p);
    logic [DEG_W-1:0] d;
    d = '0;
    for (int k = 1; k < POLY_W; k++) begin
      if (p[k]) d = DEG_W'(k);
    end
    return d;
  endfunction

  // w * x mod p, for w below 2^m and m >= 1
  function automatic logic [ELEM_W-1:0] xtime(input logic [ELEM_W-1:0] w,
                                              input logic [POLY_W-1:0] p,
                                              input logic [DEG_W-1:0]  m);
    logic [POLY_W-1:0] s;
    s = {w, 1'b0};
    if (s[m]) s = s ^ p;
    return s[ELEM_W-1:0];
  endfunction

endpackage

// ===== design/gf2m_log_exp_table_builder.sv =====
// gf2m_log_exp_table_builder: builds exponent / logarithm tables of GF(2^m)
// and answers lookups from them. Uses gfle_pkg.
// Lookup: item accepted at edge t, result strobe in the cycle after; one
//   lookup per cycle, back to back, while no build holds busy high.
// Build: the prep state reduces the generator and forms the multiplier
//   columns, the walk state then steps through the powers (up to 2^m-1) via
//   the exp and log memories' write ports, then the closing state; the strobe
//   comes in the cycle after that. busy is high from the accept edge until then.
// Reset: not built, configuration registers at their reset values; the table
//   memories are not cleared. The receiver cannot stall: each result shows for one cycle.
module gf2m_log_exp_table_builder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  gfle_pkg::in_item_t               in_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gfle_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gfle_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             out_strobe,
  output gfle_pkg::out_item_t              out_item
);

  localparam int ELEM_W = gfle_pkg::ELEM_W;
  localparam int POLY_W = gfle_pkg::POLY_W;
  localparam int DEG_W  = gfle_pkg::DEG_W;
  localparam int IDX_W  = gfle_pkg::IDX_W;
  localparam int PH_W   = gfle_pkg::PH_W;
  localparam logic [PH_W-1:0] PH_COL0 = PH_W'(ELEM_W - 1);
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(2 * ELEM_W - 2);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_WALK = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state_r;

  // configuration
  logic [POLY_W-1:0] poly_r;
  logic [ELEM_W-1:0] gen_r;

  // build datapath
  logic [DEG_W-1:0]  m_r;
  logic [ELEM_W-1:0] ord_r;
  logic [PH_W-1:0]   ph_r;
  logic [ELEM_W-1:0] g_sh_r;      // generator bits, MSB first
  logic [ELEM_W-1:0] w_r, w_nxt;  // Horner accumulator / column chain
  logic [ELEM_W-1:0] col_r [ELEM_W];  // col_r[j] = generator * x^j mod poly
  logic [ELEM_W-1:0] b_r, b_nxt;  // current power
  logic [ELEM_W-1:0] i_r;         // current exponent
  logic [ELEM_W:0]   i_inc;
  logic              walk_ok_r;

  logic              built_r;
  logic [ELEM_W-1:0] built_ord_r;

  // result staging
  logic              out_vld_r;
  logic              out_lkp_r;   // value comes from a memory read
  logic              out_log_r;   // 1: log table, 0: exp table
  logic [gfle_pkg::STAT_W-1:0] out_status_r;

  // memories
  logic [ELEM_W-1:0] exp_mem [gfle_pkg::STORE_DEPTH];
  logic [ELEM_W-1:0] log_mem [gfle_pkg::STORE_DEPTH];
  logic [ELEM_W-1:0] exp_rd_r, log_rd_r;
  logic              mem_we;
  logic [ELEM_W-1:0] exp_wa, exp_wd, log_wa, log_wd;

  logic accept, is_lookup, rd_en;
  logic [DEG_W-1:0]  deg;
  logic [POLY_W-1:0] ord_full;
  logic [IDX_W-1:0]  col_idx;
  logic              walk_done;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign is_lookup = (in_item.command == gfle_pkg::CMD_READ_EXP) ||
                     (in_item.command == gfle_pkg::CMD_READ_LOG);
  assign rd_en     = accept && is_lookup;

  assign deg      = gfle_pkg::poly_degree(poly_r);
  assign ord_full = (POLY_W'(1) << deg) - POLY_W'(1);

  // prep: Horner reduction of the generator, then repeated xtime for columns
  assign w_nxt   = gfle_pkg::xtime(w_r, poly_r, m_r) ^ {{(ELEM_W-1){1'b0}}, g_sh_r[ELEM_W-1]};
  assign col_idx = IDX_W'(ph_r - PH_COL0);

  // walk: b * generator as an XOR of selected columns
  always_comb begin
    b_nxt = '0;
    for (int j = 0; j < ELEM_W; j++) begin
      if (b_r[j]) b_nxt = b_nxt ^ col_r[j];
    end
    if (m_r == '0) b_nxt = '0;  // degree-zero modulus: every product is 0
  end

  assign i_inc     = {1'b0, i_r} + (ELEM_W+1)'(1);
  assign walk_done = (b_nxt == ELEM_W'(1)) || (i_inc >= {1'b0, ord_r});

  // memory write ports: walk records exp[i]=b, log[b]=i; close writes the ends
  assign mem_we = (state_r == S_WALK) || (state_r == S_FIN);
  assign exp_wa = (state_r == S_FIN) ? ord_r : i_r;
  assign exp_wd = (state_r == S_FIN) ? '0 : b_r;
  assign log_wa = (state_r == S_FIN) ? '0 : b_r;
  assign log_wd = (state_r == S_FIN) ? ord_r : i_r;

  always_ff @(posedge clk) begin
    if (mem_we) exp_mem[exp_wa] <= exp_wd;
    if (rd_en)  exp_rd_r <= exp_mem[in_item.operand];
  end

  always_ff @(posedge clk) begin
    if (mem_we) log_mem[log_wa] <= log_wd;
    if (rd_en)  log_rd_r <= log_mem[in_item.operand];
  end

  // configuration writes: the user must write only while idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= gfle_pkg::MODULUS_RST;
      gen_r  <= gfle_pkg::GENERATOR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        gfle_pkg::REG_MODULUS:   poly_r <= cfg_data[POLY_W-1:0];
        gfle_pkg::REG_GENERATOR: gen_r  <= cfg_data[ELEM_W-1:0];
        default: ;
      endcase
    end
  end

  // build datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept && in_item.command == gfle_pkg::CMD_BUILD) begin
          m_r    <= deg;
          ord_r  <= ord_full[ELEM_W-1:0];
          g_sh_r <= gen_r;
          w_r    <= '0;
          ph_r   <= '0;
        end
      end
      S_PREP: begin
        w_r    <= w_nxt;
        g_sh_r <= g_sh_r << 1;
        ph_r   <= ph_r + PH_W'(1);
        if (ph_r >= PH_COL0) col_r[col_idx] <= w_nxt;
        b_r <= ELEM_W'(1);
        i_r <= '0;
      end
      S_WALK: begin
        b_r       <= b_nxt;
        i_r       <= i_inc[ELEM_W-1:0];
        walk_ok_r <= (b_nxt == ELEM_W'(1)) && (i_inc == {1'b0, ord_r});
      end
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      built_r     <= 1'b0;
      built_ord_r <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      out_vld_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_item.command == gfle_pkg::CMD_BUILD) begin
              state_r <= S_PREP;
            end else begin
              // lookup or unused command: answered in the next cycle
              out_vld_r    <= 1'b1;
              out_lkp_r    <= is_lookup && built_r && (in_item.operand <= built_ord_r);
              out_log_r    <= (in_item.command == gfle_pkg::CMD_READ_LOG);
              out_status_r <= (is_lookup && !built_r) ? gfle_pkg::ST_NOT_BUILT
                                                      : gfle_pkg::ST_OK;
            end
          end
        end
        S_PREP: begin
          if (ph_r == PH_LAST) state_r <= S_WALK;
        end
        S_WALK: begin
          if (walk_done) state_r <= S_FIN;
        end
        S_FIN: begin
          state_r      <= S_IDLE;
          built_r      <= 1'b1;
          built_ord_r  <= ord_r;
          out_vld_r    <= 1'b1;
          out_lkp_r    <= 1'b0;
          out_log_r    <= 1'b0;
          out_status_r <= walk_ok_r ? gfle_pkg::ST_OK : gfle_pkg::ST_NOT_PRIM;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_strobe      = out_vld_r;
  assign out_item.value  = !out_lkp_r ? '0 : (out_log_r ? log_rd_r : exp_rd_r);
  assign out_item.status = out_status_r;

endmodule

// ===== tb/gfle_tb_pkg.sv =====
// gfle_tb_pkg: table tracker for the GF(2^m) log / exp table builder bench.
// Holds a copy of the config and both tables plus the queue of expected results.
// Depends on gfle_pkg for the item types, widths and codes.
`timescale 1ns / 1ps
package gfle_tb_pkg;
  import gfle_pkg::*;

  // command code with no meaning to the block
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  class gf_table_tracker;
    logic [POLY_W-1:0] modulus;
    logic [ELEM_W-1:0] gen;
    bit                built;
    int unsigned       built_ord;
    logic [ELEM_W-1:0] exp_tab [STORE_DEPTH];
    logic [ELEM_W-1:0] log_tab [STORE_DEPTH];
    bit                exp_set [STORE_DEPTH];
    bit                log_set [STORE_DEPTH];
    out_item_t         expected_q [$];
    int unsigned       errors;

    function new();
      modulus   = MODULUS_RST;
      gen       = GENERATOR_RST;
      built     = 1'b0;
      built_ord = 0;
      errors    = 0;
    endfunction

    function int unsigned degree_of(logic [POLY_W-1:0] p);
      int unsigned d;
      d = 0;
      while (p > 1) begin
        p = p >> 1;
        d++;
      end
      return d;
    endfunction

    // carry-less a*c, then reduced by p of degree d
    function logic [ELEM_W-1:0] mul_reduce(logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] c,
                                           logic [POLY_W-1:0] p, int unsigned d);
      logic [31:0] prod;
      prod = '0;
      if (p == '0) return '0;
      for (int k = 0; k < ELEM_W; k++) begin
        if (c[k]) prod ^= 32'(a) << k;
      end
      for (int bit_pos = 31; bit_pos >= int'(d); bit_pos--) begin
        if (prod[bit_pos]) prod ^= 32'(p) << (bit_pos - int'(d));
      end
      return prod[ELEM_W-1:0];
    endfunction

    function logic [STAT_W-1:0] run_build();
      int unsigned       m, ord, i;
      logic [ELEM_W-1:0] b;
      m = degree_of(modulus);
      ord = (1 << m) - 1;
      b = 1;
      i = 0;
      do begin
        exp_tab[i] = b;
        exp_set[i] = 1'b1;
        log_tab[b] = ELEM_W'(i);
        log_set[b] = 1'b1;
        b = mul_reduce(b, gen, modulus, m);
        i++;
      end while (b != 1 && i < ord);
      exp_tab[ord] = '0;
      exp_set[ord] = 1'b1;
      log_tab[0]   = ELEM_W'(ord);
      log_set[0]   = 1'b1;
      built     = 1'b1;
      built_ord = ord;
      return (b == 1 && i == ord) ? ST_OK : ST_NOT_PRIM;
    endfunction

    // false only for a lookup that would land on a never-written entry
    function bit read_is_defined(in_item_t it);
      if (it.command != CMD_READ_EXP && it.command != CMD_READ_LOG) return 1'b1;
      if (!built || it.operand > built_ord) return 1'b1;
      return (it.command == CMD_READ_EXP) ? exp_set[it.operand] : log_set[it.operand];
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_MODULUS) modulus = data;
      else gen = data[ELEM_W-1:0];
    endfunction

    function void note_command(in_item_t it);
      out_item_t r;
      r.value  = '0;
      r.status = ST_OK;
      case (it.command)
        CMD_BUILD: r.status = run_build();
        CMD_READ_EXP, CMD_READ_LOG: begin
          if (!built) r.status = ST_NOT_BUILT;
          else if (it.operand <= built_ord)
            r.value = (it.command == CMD_READ_EXP) ? exp_tab[it.operand] : log_tab[it.operand];
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: value %0d status %0d", got.value, got.status);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.value !== want.value) begin
        $error("value: expected %0d, actual %0d", want.value, got.value);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

// ===== tb/gf2m_log_exp_table_builder_tb.sv =====
// gf2m_log_exp_table_builder_tb: top-level bench for the GF(2^m) table builder.
// Drives builds and lookups, checks every result against gf_table_tracker.
// Depends on gfle_pkg and gfle_tb_pkg.
`timescale 1ns / 1ps
module gf2m_log_exp_table_builder_tb;
  import gfle_pkg::*;
  import gfle_tb_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  out_strobe;
  out_item_t             out_item;

  gf_table_tracker tracker = new();

  // sender gaps on/off; one stretch of phases runs with none
  bit idle_enabled;

  gf2m_log_exp_table_builder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Results show for one cycle only; sample every edge after reset.
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) tracker.check_result(out_item);
  end

  // Hang guard: covers far more full-size builds than the stimulus can issue.
  initial begin
    #150_000_000;
    $display("gf2m_log_exp_table_builder: mismatch");
    $finish;
  end

  // Hold start with the item until the block takes it (start high, busy low).
  task automatic send_item(input in_item_t it);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_command(it);
  endtask

  // One item. A lookup that would hit an entry no build has written is
  // steered to entry 0, which every build writes in both tables.
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [ELEM_W-1:0] opnd);
    in_item_t it;
    it.command = cmd;
    it.operand = opnd;
    if (!tracker.read_is_defined(it)) it.operand = '0;
    send_item(it);
    if (idle_enabled && $urandom_range(99) < 29) begin
      start <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
  endtask

  // Stop sending until every expected item is back and the block is idle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0 || busy) @(posedge clk);
  endtask

  // Register write; only called with the block idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    if (idle_enabled && $urandom_range(99) < 29) repeat ($urandom_range(4, 1)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.note_config(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // primitive polynomials, so that x generates the whole field
  function automatic logic [POLY_W-1:0] prim_poly(input int unsigned m);
    case (m)
      1:       return POLY_W'(13'h3);
      2:       return POLY_W'(13'h7);
      3:       return POLY_W'(13'hB);
      4:       return POLY_W'(13'h13);
      5:       return POLY_W'(13'h25);
      6:       return POLY_W'(13'h43);
      7:       return POLY_W'(13'h89);
      8:       return POLY_W'(13'h11D);
      9:       return POLY_W'(13'h211);
      10:      return POLY_W'(13'h409);
      11:      return POLY_W'(13'h805);
      default: return POLY_W'(13'h1053);
    endcase
  endfunction

  initial begin
    int unsigned       m, ord, n, r;
    int unsigned       random_items, phase;
    logic [POLY_W-1:0] poly;
    logic [ELEM_W-1:0] gen, opnd;
    logic [CMD_W-1:0]  cmd;

    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_item      <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    idle_enabled = 1'b1;
    random_items = 0;
    phase        = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // lookups and an unused command before any build
    issue(CMD_READ_EXP, 12'h000);
    issue(CMD_READ_LOG, 12'hFFF);
    issue(CMD_UNUSED, 12'hFFF);
    // build with the reset config: full 12-bit field, generator x
    issue(CMD_BUILD, 12'hFFF);
    issue(CMD_READ_EXP, 12'hFFF);
    issue(CMD_READ_LOG, 12'hFFF);
    issue(CMD_READ_LOG, 12'h000);
    issue(CMD_UNUSED, 12'h000);
    drain();
    // zero generator in GF(16): walk never gets back to 1
    write_reg(REG_MODULUS, CFG_DATA_W'(13'h13));
    write_reg(REG_GENERATOR, CFG_DATA_W'(13'h0000));
    issue(CMD_BUILD, 12'h000);
    issue(CMD_READ_EXP, 12'd15);
    issue(CMD_READ_EXP, 12'd16);     // beyond the field
    issue(CMD_READ_LOG, 12'd0);
    issue(CMD_READ_LOG, 12'd1);
    drain();
    // generator wider than the field, reduced on the first multiply
    write_reg(REG_GENERATOR, CFG_DATA_W'(13'h1FFF));
    issue(CMD_BUILD, 12'h000);
    issue(CMD_READ_LOG, 12'd1);
    issue(CMD_READ_EXP, 12'd3);
    drain();
    // degree-zero polynomials
    write_reg(REG_MODULUS, CFG_DATA_W'(13'h1));
    issue(CMD_BUILD, 12'h000);
    issue(CMD_READ_EXP, 12'd0);
    issue(CMD_READ_LOG, 12'd1);
    drain();
    write_reg(REG_MODULUS, CFG_DATA_W'(13'h0));
    issue(CMD_BUILD, 12'h000);
    issue(CMD_READ_LOG, 12'd0);
    drain();
    // top modulus value with the widest generator
    write_reg(REG_MODULUS, CFG_DATA_W'(13'h1FFF));
    issue(CMD_BUILD, 12'h000);
    issue(CMD_READ_EXP, 12'hFFF);

    // --- random phases: new field, build, then mostly lookups ---
    while (random_items < 550) begin
      drain();
      idle_enabled = !(phase == 2 || phase == 3);

      // field size: mostly small, rarely the full 12 bits
      r = $urandom_range(99);
      if (r < 4) m = $urandom_range(1, 0);
      else if (r < 60) m = $urandom_range(5, 2);
      else if (r < 85) m = $urandom_range(8, 6);
      else if (r < 95) m = $urandom_range(11, 9);
      else m = 12;

      if (m == 0) poly = POLY_W'($urandom_range(1, 0));
      else if ($urandom_range(99) < 70) poly = prim_poly(m);
      else poly = POLY_W'((1 << m) | ($urandom() & ((1 << m) - 1)));

      r = $urandom_range(99);
      if (r < 5) gen = '0;
      else if (r < 50) gen = ELEM_W'(2);
      else if (r < 80 && m > 0) gen = ELEM_W'($urandom_range((1 << m) - 1, 1));
      else gen = ELEM_W'($urandom());

      if ($urandom_range(1)) begin
        write_reg(REG_MODULUS, poly);
        write_reg(REG_GENERATOR, {1'($urandom_range(1)), gen});
      end else begin
        write_reg(REG_GENERATOR, {1'($urandom_range(1)), gen});
        write_reg(REG_MODULUS, poly);
      end

      // now and then look up the old tables under the new config
      if ($urandom_range(99) < 90) begin
        issue(CMD_BUILD, ELEM_W'($urandom()));
        random_items++;
      end

      n = $urandom_range(40, 15);
      repeat (n) begin
        r = $urandom_range(99);
        if (r < 43) cmd = CMD_READ_EXP;
        else if (r < 86) cmd = CMD_READ_LOG;
        else if (r < 92) cmd = CMD_BUILD;
        else cmd = CMD_UNUSED;

        ord = tracker.built ? tracker.built_ord : 4095;
        r = $urandom_range(99);
        if (r < 80) opnd = ELEM_W'($urandom_range(ord, 0));
        else if (r < 90) begin
          case ($urandom_range(2))
            0:       opnd = '0;
            1:       opnd = ELEM_W'(ord);
            default: opnd = ELEM_W'(ord + 1);
          endcase
        end else opnd = ELEM_W'($urandom());

        issue(cmd, opnd);
        if (cmd != CMD_UNUSED) random_items++;
        // occasional hold-off until the block has answered everything
        if ($urandom_range(99) < 3) drain();
      end
      phase++;
    end

    drain();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("gf2m_log_exp_table_builder: match");
    end else begin
      $display("gf2m_log_exp_table_builder: mismatch");
    end
    $finish;
  end

endmodule
